>>> hdl/trm_pkg.sv
// Package for the timestamp rate meter: widths, codes, controller states
// and the divider status bundle. No dependencies.
`timescale 1ns / 1ps

package trm_pkg;

  localparam int COUNT_BITS    = 20;
  localparam int FRACTION_BITS = 8;
  localparam int TS_W          = 64;
  localparam int TPS_W         = 30;
  localparam int FREQ_W        = 58;
  localparam int INTERVALS_W   = 20;

  localparam int PROD_W    = COUNT_BITS + TPS_W;
  localparam int NUM_W     = PROD_W + FRACTION_BITS;
  localparam int DIV_W     = (NUM_W > FREQ_W) ? NUM_W : FREQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_TPS   = '0;
  localparam logic [TPS_W-1:0]     TPS_RESET = TPS_W'(1000000000);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [DIV_W-1:0]      FREQ_MAX      = DIV_W'({FREQ_W{1'b1}});
  localparam logic [31:0]           INTERVALS_MAX = 32'({INTERVALS_W{1'b1}});

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp the window count to the width of the reported interval field.
  function automatic logic [INTERVALS_W-1:0] sat_intervals(input logic [COUNT_BITS-1:0] c);
    logic [INTERVALS_W-1:0] r;
    if (32'(c) > INTERVALS_MAX) begin
      r = '1;
    end else begin
      r = INTERVALS_W'(c);
    end
    return r;
  endfunction

endpackage

>>> hdl/trm_in_if.sv
// Input channel of the timestamp rate meter: valid/ready plus one sample item.
// Depends on trm_pkg.
`timescale 1ns / 1ps

interface trm_in_if
  import trm_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [TS_W-1:0] timestamp_ns;

  modport source (output valid, output operation, output timestamp_ns, input ready);
  modport sink (input valid, input operation, input timestamp_ns, output ready);
endinterface

>>> hdl/trm_out_if.sv
// Output channel of the timestamp rate meter: valid/ready plus one report item.
// Depends on trm_pkg.
`timescale 1ns / 1ps

interface trm_out_if
  import trm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [FREQ_W-1:0]      frequency_q8;
  logic [INTERVALS_W-1:0] intervals;
  logic [TS_W-1:0]        elapsed_ticks;

  modport source (output valid, output frequency_q8, output intervals, output elapsed_ticks,
                  input ready);
  modport sink (input valid, input frequency_q8, input intervals, input elapsed_ticks,
                output ready);
endinterface

>>> hdl/timestamp_rate_meter.sv
// Top level of the timestamp rate meter: sequencer, window state and output register.
// Depends on trm_pkg, trm_in_if, trm_out_if, trm_apb and trm_div.
`timescale 1ns / 1ps

// The block measures an event rate from a stream of event timestamps.
// Items arrive on the in_i channel. A sample item (operation = 0) carries a
// timestamp; when a previous non-zero timestamp is held and the new one is
// larger, the gap is added to the window sum and one interval is counted.
// The new timestamp always becomes the held one. A report item (operation = 1)
// produces one transfer on out_o with the rate in Hz (8 fraction bits), the
// interval count and the summed gap of the window, then clears the window.
// The ticks_per_second register is written over the APB port at address 0;
// it resets to one billion (nanosecond ticks). The user must write it only
// while the block is idle; the block itself does not enforce this.
// A sample item forms the gap at the accepting edge; the 64-bit adder updates
// the window sum in the next cycle. A report passes through the multiply state,
// the divider and its done flag, and the load of the output register; the next
// item is accepted after that. An empty window skips the divider.
// Ready is low while an item is in progress. The finished result sits in the
// output register, so the block keeps taking samples while the receiver
// stalls; only a second report waits until the first result is taken.
// Reset clears the held timestamp, the window and the output valid flag.
module timestamp_rate_meter
  import trm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  trm_in_if.sink                in_i,
  trm_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_e                 state_q;
  state_e                 state_d;

  logic [TPS_W-1:0]       tps;
  logic                   in_fire;
  logic                   is_report;
  logic                   out_load;
  logic                   div_start;
  div_stat_t              div_stat;
  logic [DIV_W-1:0]       div_num;
  logic [DIV_W-1:0]       div_quot;
  logic [PROD_W-1:0]      prod;
  logic [TS_W:0]          sum_ext;

  logic [TS_W-1:0]        last_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic [TS_W-1:0]        sum_q;
  logic [TS_W-1:0]        gap_q;
  logic                   gap_ok_q;
  logic [COUNT_BITS-1:0]  count_snap_q;
  logic [TS_W-1:0]        sum_snap_q;
  logic                   zero_q;

  logic                   out_valid_q;
  logic [FREQ_W-1:0]      freq_q;
  logic [INTERVALS_W-1:0] intervals_q;
  logic [TS_W-1:0]        elapsed_q;
  logic [FREQ_W-1:0]      freq_d;

  trm_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tps_o   (tps)
  );

  trm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_snap_q),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  assign in_fire   = in_i.valid && in_i.ready;
  assign is_report = (in_i.operation == OP_REPORT);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = is_report ? ST_MUL : ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = ST_IDLE;
      end
      ST_MUL: begin
        state_d = zero_q ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_MUL:  div_start  = !zero_q;
      ST_OUT:  out_load   = !out_valid_q || out_o.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window state. The gap and its qualification are formed at acceptance;
  // the adder applies them in the next cycle.
  assign sum_ext = {1'b0, sum_q} + {1'b0, gap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      gap_ok_q <= 1'b0;
    end else begin
      if (in_fire && !is_report) begin
        last_q   <= in_i.timestamp_ns;
        gap_ok_q <= (last_q != '0) && (in_i.timestamp_ns > last_q);
      end
      if (in_fire && is_report) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if ((state_q == ST_ADD) && gap_ok_q) begin
        sum_q <= sum_ext[TS_W] ? '1 : sum_ext[TS_W-1:0];
        if (count_q != COUNT_MAX) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !is_report) begin
      gap_q <= in_i.timestamp_ns - last_q;
    end
    if (in_fire && is_report) begin
      count_snap_q <= count_q;
      sum_snap_q   <= sum_q;
      zero_q       <= (count_q == '0) || (sum_q == '0);
    end
  end

  // One multiply feeds the divider register directly; the fraction bits are
  // a plain shift of the numerator.
  assign prod    = PROD_W'(count_snap_q) * PROD_W'(tps);
  assign div_num = DIV_W'(prod) << FRACTION_BITS;

  always_comb begin
    if (zero_q) begin
      freq_d = '0;
    end else if (div_quot > FREQ_MAX) begin
      freq_d = '1;
    end else begin
      freq_d = div_quot[FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      freq_q      <= freq_d;
      intervals_q <= sat_intervals(count_snap_q);
      elapsed_q   <= sum_snap_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.frequency_q8  = freq_q;
  assign out_o.intervals     = intervals_q;
  assign out_o.elapsed_ticks = elapsed_q;

  // A report transfer always empties the window.
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_report) |=> (count_q == '0) && (sum_q == '0))
    else $error("window not cleared after report");

  // The interval count only steps by one or returns to zero.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == COUNT_BITS'($past(count_q) + 1'b1)) || (count_q == '0)))
    else $error("interval count jumped");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  // The divider is started only when it is idle.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A sample transfer keeps the input stalled for the adder cycle.
  a_sample_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_report) |=> !in_i.ready)
    else $error("input ready during window update");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("pending result overwritten");

endmodule

>>> hdl/trm_apb.sv
// APB configuration register block holding ticks_per_second.
// Depends on trm_pkg.
`timescale 1ns / 1ps

module trm_apb
  import trm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [TPS_W-1:0]      tps_o
);

  logic [TPS_W-1:0]     tps_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (wr_en && (reg_idx == REG_TPS)) begin
      tps_q <= pwdata[TPS_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_TPS) ? APB_DATA_W'(tps_q) : '0;
  assign tps_o  = tps_q;

endmodule

>>> hdl/trm_div.sv
// Restoring divider, one quotient bit per cycle, for the rate computation.
// Depends on trm_pkg.
`timescale 1ns / 1ps

module trm_div
  import trm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [TS_W-1:0]  den_i,
  output logic [DIV_W-1:0] quot_o,
  output div_stat_t        stat_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TS_W-1:0]      rem_q;
  logic [TS_W-1:0]      rem_d;
  logic [TS_W-1:0]      den_q;
  logic [DIV_W-1:0]     nq_q;
  logic [DIV_W-1:0]     nq_d;
  logic [TS_W:0]        shifted;
  logic [TS_W+1:0]      diff;
  logic                 ge;

  // The numerator shifts out at the top while quotient bits shift in below.
  always_comb begin
    shifted = {rem_q, nq_q[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = !diff[TS_W+1];
    rem_d   = ge ? diff[TS_W-1:0] : shifted[TS_W-1:0];
    nq_d    = {nq_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nq_q  <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
    end
  end

  assign quot_o      = nq_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
